@@ rtl/stsir_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted table package
// Types and constants shared by the sorted key/value table.
// ----------------------------------------------------------------------------
`default_nettype none

package stsir_pkg;

  localparam int unsigned DefTableDepth = 1024;
  localparam int unsigned DefKeyBits    = 64;
  localparam int unsigned ValueBits     = 64;
  localparam int unsigned PosW          = 10;
  localparam int unsigned EntW          = 11;
  localparam int unsigned InDataW       = 136;
  localparam int unsigned OutDataW      = 88;

  typedef enum logic [1:0] {
    MODE_FIND,
    MODE_INSERT,
    MODE_REMOVE,
    MODE_CLEAR
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_NOT_FOUND,
    STAT_DUPLICATE,
    STAT_FULL
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_HIT_RD,
    ST_HIT_CHK,
    ST_INS_SHIFT,
    ST_INS_LAST,
    ST_INS_PUT,
    ST_RM_SHIFT,
    ST_RM_LAST,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

@@ rtl/sorted_table_search_insert_remove.sv @@
// ----------------------------------------------------------------------------
// Sorted table with search, insert and remove
// Key/value table kept in ascending key order in one synchronous memory.
// ----------------------------------------------------------------------------
// Find runs a binary search loop through the registered memory read, then reads
// and checks the entry at the found position; clear only resets the entry count.
// An insert moves the entries at and above its position up by one, last first,
// and a remove moves the entries above the hit down by one. One item is worked
// on at a time; the next item is accepted in the cycle after the result is registered.
// Reset empties the table; memory contents are left undefined.
`default_nettype none

module sorted_table_search_insert_remove #(
  parameter int unsigned TABLE_DEPTH = stsir_pkg::DefTableDepth,
  parameter int unsigned KEY_BITS    = stsir_pkg::DefKeyBits
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // mode[1:0], key[65:2], value[129:66], zero fill
  input  wire logic [stsir_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // status[1:0], position[11:2], payload[75:12], entries[86:76], zero fill
  output logic [stsir_pkg::OutDataW-1:0]        m_axis_tdata
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned MemW = KEY_BITS + stsir_pkg::ValueBits;
  localparam logic [CntW-1:0] DepthC = CntW'(TABLE_DEPTH);
  localparam logic [CntW-1:0] OneC   = CntW'(1);

  stsir_pkg::state_e  state_q, state_d;
  stsir_pkg::mode_e   mode_q, mode_d;
  stsir_pkg::status_e res_status_q, res_status_d;

  logic [KEY_BITS-1:0]             key_q, key_d;
  logic [stsir_pkg::ValueBits-1:0] val_q, val_d;
  logic [CntW-1:0]                 count_q, count_d;
  logic [CntW-1:0]                 lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, j_q, j_d;
  logic [stsir_pkg::PosW-1:0]      res_pos_q, res_pos_d;
  logic [stsir_pkg::ValueBits-1:0] res_pay_q, res_pay_d;
  logic                            wr_pend_q, wr_pend_d;
  logic [IdxW-1:0]                 wr_addr_q, wr_addr_d;
  logic                            m_valid_q, m_valid_d;
  logic [stsir_pkg::OutDataW-1:0]  m_data_q, m_data_d;

  logic [MemW-1:0] table_mem [TABLE_DEPTH];
  logic [MemW-1:0] rdata_q;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr, mem_raddr;
  logic [MemW-1:0] mem_wdata;

  logic [CntW-1:0]                 mid, lo_inc, cnt_dec, j_inc, j_dec;
  logic [KEY_BITS-1:0]             rkey;
  logic [stsir_pkg::ValueBits-1:0] rval;
  logic                            in_acc, lo_in, key_hit, room, rm_more, out_free;
  logic [stsir_pkg::PosW+CntW-1:0] pos_ext;
  logic [stsir_pkg::EntW+CntW-1:0] ent_ext;
  stsir_pkg::mode_e                in_mode;

  assign in_mode  = stsir_pkg::mode_e'(s_axis_tdata[1:0]);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign mid      = lo_q + ((hi_q - lo_q) >> 1);
  assign lo_inc   = lo_q + OneC;
  assign cnt_dec  = count_q - OneC;
  assign j_inc    = j_q + OneC;
  assign j_dec    = j_q - OneC;
  assign rkey     = rdata_q[KEY_BITS-1:0];
  assign rval     = rdata_q[MemW-1:KEY_BITS];
  assign lo_in    = lo_q < count_q;
  assign key_hit  = rkey == key_q;
  assign room     = count_q < DepthC;
  assign rm_more  = lo_inc < count_q;
  assign out_free = !m_valid_q || m_axis_tready;
  assign pos_ext  = {{stsir_pkg::PosW{1'b0}}, lo_q};
  assign ent_ext  = {{stsir_pkg::EntW{1'b0}}, count_q};

  assign s_axis_tready = state_q == stsir_pkg::ST_IDLE;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      stsir_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = (in_mode == stsir_pkg::MODE_CLEAR) ? stsir_pkg::ST_DONE
                                                       : stsir_pkg::ST_SRCH_RD;
        end
      end
      stsir_pkg::ST_SRCH_RD: begin
        state_d = (lo_q < hi_q) ? stsir_pkg::ST_SRCH_CMP : stsir_pkg::ST_HIT_RD;
      end
      stsir_pkg::ST_SRCH_CMP: state_d = stsir_pkg::ST_SRCH_RD;
      stsir_pkg::ST_HIT_RD, stsir_pkg::ST_HIT_CHK: begin
        if (state_q == stsir_pkg::ST_HIT_RD && lo_in) begin
          state_d = stsir_pkg::ST_HIT_CHK;
        end else if (state_q == stsir_pkg::ST_HIT_CHK && key_hit) begin
          state_d = (mode_q == stsir_pkg::MODE_REMOVE && rm_more) ? stsir_pkg::ST_RM_SHIFT
                                                                  : stsir_pkg::ST_DONE;
        end else if (mode_q == stsir_pkg::MODE_INSERT && room) begin
          state_d = (count_q > lo_q) ? stsir_pkg::ST_INS_SHIFT : stsir_pkg::ST_INS_PUT;
        end else begin
          state_d = stsir_pkg::ST_DONE;
        end
      end
      stsir_pkg::ST_INS_SHIFT: begin
        if (j_q == lo_q) begin
          state_d = stsir_pkg::ST_INS_LAST;
        end
      end
      stsir_pkg::ST_INS_LAST: state_d = stsir_pkg::ST_INS_PUT;
      stsir_pkg::ST_INS_PUT:  state_d = stsir_pkg::ST_DONE;
      stsir_pkg::ST_RM_SHIFT: begin
        if (j_q == cnt_dec) begin
          state_d = stsir_pkg::ST_RM_LAST;
        end
      end
      stsir_pkg::ST_RM_LAST: state_d = stsir_pkg::ST_DONE;
      stsir_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = stsir_pkg::ST_IDLE;
        end
      end
      default: state_d = stsir_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    mode_d       = mode_q;
    key_d        = key_q;
    val_d        = val_q;
    count_d      = count_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mid_d        = mid_q;
    j_d          = j_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    res_pay_d    = res_pay_q;
    wr_pend_d    = wr_pend_q;
    wr_addr_d    = wr_addr_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    m_data_d     = m_data_q;
    mem_raddr    = mid[IdxW-1:0];
    mem_we       = wr_pend_q;
    mem_waddr    = wr_addr_q;
    mem_wdata    = rdata_q;
    case (state_q)
      stsir_pkg::ST_IDLE: begin
        if (in_acc) begin
          mode_d       = in_mode;
          key_d        = s_axis_tdata[KEY_BITS+1:2];
          val_d        = s_axis_tdata[129:66];
          lo_d         = '0;
          hi_d         = count_q;
          res_status_d = stsir_pkg::STAT_OK;
          res_pos_d    = '0;
          res_pay_d    = '0;
          if (in_mode == stsir_pkg::MODE_CLEAR) begin
            count_d = '0;
          end
        end
      end
      stsir_pkg::ST_SRCH_RD: mid_d = mid;
      stsir_pkg::ST_SRCH_CMP: begin
        if (rkey < key_q) begin
          lo_d = mid_q + OneC;
        end else begin
          hi_d = mid_q;
        end
      end
      stsir_pkg::ST_HIT_RD, stsir_pkg::ST_HIT_CHK: begin
        mem_raddr = lo_q[IdxW-1:0];
        if (state_q == stsir_pkg::ST_HIT_RD && lo_in) begin
          res_status_d = res_status_q;
        end else if (state_q == stsir_pkg::ST_HIT_CHK && key_hit) begin
          case (mode_q)
            stsir_pkg::MODE_INSERT: res_status_d = stsir_pkg::STAT_DUPLICATE;
            stsir_pkg::MODE_REMOVE: begin
              res_pos_d = pos_ext[stsir_pkg::PosW-1:0];
              res_pay_d = rval;
              j_d       = lo_inc;
              if (!rm_more) begin
                count_d = cnt_dec;
              end
            end
            default: begin
              res_pos_d = pos_ext[stsir_pkg::PosW-1:0];
              res_pay_d = rval;
            end
          endcase
        end else if (mode_q == stsir_pkg::MODE_INSERT) begin
          if (room) begin
            res_pos_d = pos_ext[stsir_pkg::PosW-1:0];
            j_d       = cnt_dec;
          end else begin
            res_status_d = stsir_pkg::STAT_FULL;
          end
        end else begin
          res_status_d = stsir_pkg::STAT_NOT_FOUND;
        end
      end
      stsir_pkg::ST_INS_SHIFT: begin
        mem_raddr = j_q[IdxW-1:0];
        wr_pend_d = 1'b1;
        wr_addr_d = j_inc[IdxW-1:0];
        j_d       = j_dec;
      end
      stsir_pkg::ST_INS_LAST: wr_pend_d = 1'b0;
      stsir_pkg::ST_INS_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = lo_q[IdxW-1:0];
        mem_wdata = {val_q, key_q};
        count_d   = count_q + OneC;
      end
      stsir_pkg::ST_RM_SHIFT: begin
        mem_raddr = j_q[IdxW-1:0];
        wr_pend_d = 1'b1;
        wr_addr_d = j_dec[IdxW-1:0];
        j_d       = j_inc;
      end
      stsir_pkg::ST_RM_LAST: begin
        wr_pend_d = 1'b0;
        count_d   = cnt_dec;
      end
      stsir_pkg::ST_DONE: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {1'b0, ent_ext[stsir_pkg::EntW-1:0], res_pay_q, res_pos_q,
                       res_status_q};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= stsir_pkg::ST_IDLE;
      count_q   <= '0;
      wr_pend_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      wr_pend_q <= wr_pend_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    key_q        <= key_d;
    val_q        <= val_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    mid_q        <= mid_d;
    j_q          <= j_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    res_pay_q    <= res_pay_d;
    wr_addr_q    <= wr_addr_d;
    m_data_q     <= m_data_d;
  end

  // Shifts read one entry ahead of the write, so a read and a write never hit
  // the same entry in one cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= table_mem[mem_raddr];
  end

endmodule

`default_nettype wire
